// File: rtl/p2g_pkg.sv
// Shared types, register codes and constants for the pixel-to-glyph run encoder.
// Also holds the elaboration-time gamma table builder used by the front end.
// No dependencies.
`default_nettype none

package p2g_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_COLOR_ENABLE      = 3'd0,
      CSR_GLYPH_SET         = 3'd1,
      CSR_GAMMA_ENABLE      = 3'd2,
      CSR_CONTRAST_GAIN     = 3'd3,
      CSR_BRIGHTNESS_OFFSET = 3'd4,
      CSR_SINGLE_CHANNEL    = 3'd5
   } p2g_csr_type;

   // Glyph set selector codes (code 3 behaves as the clean set)
   localparam logic [1:0] GSET_CLEAN = 2'd0;
   localparam logic [1:0] GSET_FINE  = 2'd1;
   localparam logic [1:0] GSET_BLOCK = 2'd2;

   // Largest glyph index of each set
   localparam logic [6:0] GMAX_CLEAN = 7'd9;
   localparam logic [6:0] GMAX_FINE  = 7'd67;
   localparam logic [6:0] GMAX_BLOCK = 7'd4;

   // Rec.601 weights in Q16 (sum 65536)
   localparam logic [14:0] WEIGHT_RED   = 15'd19595;
   localparam logic [15:0] WEIGHT_GREEN = 16'd38470;
   localparam logic [12:0] WEIGHT_BLUE  = 13'd7471;
   localparam logic [6:0]  ROUND_255    = 7'd127;

   // n / 255 == (n * RECIP_255) >> 32, exact for n below 16909320
   localparam logic [24:0] RECIP_255    = 25'd16843010;

   localparam logic [16:0] ONE_Q16      = 17'd65536;
   localparam logic [17:0] SMOOTH_THREE = 18'd196608;

   // Queue between front end and run merger
   localparam int QUEUE_DEPTH = 4;

   // One pixel after glyph mapping
   typedef struct packed {
      logic [6:0]  glyph;
      logic [23:0] color;    // red, green, blue from the top bits down
      logic        row_end;
   } p2g_item_type;

   // Settings seen by the front end
   typedef struct packed {
      logic               single_channel;
      logic               gamma_enable;
      logic [1:0]         glyph_set;
      logic [15:0]        contrast_gain;
      logic signed [17:0] brightness_offset;
   } p2g_front_cfg_type;

   // Queue handshake toward its consumer
   typedef struct packed {
      logic         empty;
      p2g_item_type head;
   } p2g_queue_out_type;

   // log2 with 24 fraction bits by truncating repeated squaring
   function automatic longint lg_fix(input longint n);
      longint unsigned m;
      longint          r;
      int              k;
      k = 0;
      for (int b = 0; b < 40; b++) begin
         if ((n >>> b) != 0) k = b;
      end
      if (n == 0) return 0;
      m = longint'(unsigned'(n)) << (30 - k);
      r = longint'(k) <<< 24;
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            r = r + (64'sd1 <<< i);
         end
      end
      return r;
   endfunction

   // Largest y in 1..65535 with g100*(lg(y)-16) <= 100*(lg(2i+1)-(bits+1)), else 0
   function automatic logic [15:0] gamma_entry(input int idx, input int g100, input int bits);
      longint target;
      longint lhs;
      longint lo;
      longint hi;
      longint mid;
      target = 64'sd100 * (lg_fix(longint'(2 * idx + 1)) - (longint'(bits + 1) <<< 24));
      lo = 0;
      hi = 65535;
      for (int it = 0; it < 17; it++) begin
         if (lo < hi) begin
            mid = (lo + hi + 1) >>> 1;
            lhs = longint'(g100) * (lg_fix(mid) - (64'sd16 <<< 24));
            if (lhs <= target) lo = mid;
            else hi = mid - 1;
         end
      end
      return lo[15:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/pixel_to_glyph_run_encoder_core.sv
// Pixel-to-glyph run encoder. Pixels enter on req_ at up to one per cycle unless
// a full queue holds the pipe, and pass an eight-stage glyph pipeline into a
// four-entry queue; the run merger drains up to one queued pixel per cycle into a
// registered result port, waiting while a pixel needs that port and it is occupied.
// A pixel that both breaks a run and ends a row yields two results and stays at
// the queue head until the second is issued. The gamma ROM is built at
// elaboration, so the block is ready right after reset.
// Depends on p2g_pkg, p2g_front, p2g_queue and p2g_back.
`default_nettype none

module pixel_to_glyph_run_encoder_core
   import p2g_pkg::*;
#(
   parameter int MAX_ROW_PIXELS   = 1024,
   parameter int GAMMA_TIMES_100  = 220,
   parameter int GAMMA_INDEX_BITS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // pixel input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  wire logic        req_tlast,   // row_end
   // run output
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // glyph [6:0], run_red [14:7], run_green [22:15],
                                         // run_blue [30:23], run_length [41:31], zero [47:42]
   output logic             rsp_tlast,   // last_in_row
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [17:0] csr_wdata
);

   // configuration registers
   logic               color_enable_ff;
   logic [1:0]         glyph_set_ff;
   logic               gamma_enable_ff;
   logic [15:0]        contrast_gain_ff;
   logic signed [17:0] brightness_offset_ff;
   logic               single_channel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_enable_ff      <= 1'b0;
         glyph_set_ff         <= GSET_CLEAN;
         gamma_enable_ff      <= 1'b0;
         contrast_gain_ff     <= 16'd4096;
         brightness_offset_ff <= '0;
         single_channel_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COLOR_ENABLE:      color_enable_ff      <= csr_wdata[0];
            CSR_GLYPH_SET:         glyph_set_ff         <= csr_wdata[1:0];
            CSR_GAMMA_ENABLE:      gamma_enable_ff      <= csr_wdata[0];
            CSR_CONTRAST_GAIN:     contrast_gain_ff     <= csr_wdata[15:0];
            CSR_BRIGHTNESS_OFFSET: brightness_offset_ff <= signed'(csr_wdata);
            CSR_SINGLE_CHANNEL:    single_channel_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   p2g_front_cfg_type front_cfg;
   assign front_cfg.single_channel    = single_channel_ff;
   assign front_cfg.gamma_enable      = gamma_enable_ff;
   assign front_cfg.glyph_set         = glyph_set_ff;
   assign front_cfg.contrast_gain     = contrast_gain_ff;
   assign front_cfg.brightness_offset = brightness_offset_ff;

   logic              q_push, q_full, q_pop;
   p2g_item_type      q_item;
   p2g_queue_out_type q_out;

   p2g_front #(
      .GAMMA_TIMES_100  (GAMMA_TIMES_100),
      .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (front_cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_red     (req_tdata[7:0]),
      .in_green   (req_tdata[15:8]),
      .in_blue    (req_tdata[23:16]),
      .in_row_end (req_tlast),
      .push       (q_push),
      .push_item  (q_item),
      .queue_full (q_full)
   );

   p2g_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .qout      (q_out)
   );

   logic [6:0]  out_glyph;
   logic [23:0] out_color;
   logic [10:0] out_length;

   p2g_back #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .color_enable (color_enable_ff),
      .qout         (q_out),
      .pop          (q_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_glyph    (out_glyph),
      .out_color    (out_color),
      .out_length   (out_length),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, out_length, out_color[7:0], out_color[15:8], out_color[23:16],
                       out_glyph};

endmodule

`default_nettype wire

// File: rtl/p2g_queue.sv
// Short item queue between the glyph front end and the run merger.
// Depends on p2g_pkg for the item type.
`default_nettype none

module p2g_queue
   import p2g_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire p2g_item_type      push_item,
   output logic                   full,
   input  wire logic              pop,
   output p2g_queue_out_type      qout
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(QUEUE_DEPTH);

   p2g_item_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign qout.empty = (count_ff == '0);
   assign qout.head  = slot_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && !qout.empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = rd_ptr_ff + 1'b1;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

`default_nettype wire

// File: rtl/p2g_front.sv
// Front end: takes pixels and maps each to a glyph through an eight-stage pipeline
// (luminance, /255, gamma ROM, gain, brightness clamp, smoothstep, quantize).
// Depends on p2g_pkg; feeds p2g_queue.
`default_nettype none

module p2g_front
   import p2g_pkg::*;
#(
   parameter int GAMMA_TIMES_100  = 220,
   parameter int GAMMA_INDEX_BITS = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire p2g_front_cfg_type cfg,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [7:0]    in_red,
   input  wire logic [7:0]    in_green,
   input  wire logic [7:0]    in_blue,
   input  wire logic          in_row_end,
   output logic               push,
   output p2g_item_type       push_item,
   input  wire logic          queue_full
);

   localparam int GT_SIZE   = 2 ** GAMMA_INDEX_BITS;
   localparam int IDX_SHIFT = 16 - GAMMA_INDEX_BITS;

   // gamma ROM, contents fixed at elaboration
   logic [15:0] gamma_rom [GT_SIZE];
   for (genvar gi = 0; gi < GT_SIZE; gi++) begin : g_rom
      localparam logic [15:0] ENTRY = gamma_entry(gi, GAMMA_TIMES_100, GAMMA_INDEX_BITS);
      assign gamma_rom[gi] = ENTRY;
   end

   // stage valids and pass-along payload
   logic [7:0]  valid_ff;
   logic        advance;
   logic [23:0] color_ff [8];
   logic [7:0]  row_end_ff;

   // arithmetic registers
   logic [23:0] num_ff;        // stage 1: weighted sum + rounding
   logic [16:0] lum2_ff;       // stage 2: luminance Q1.16
   logic [16:0] lum3_ff;       // stage 3: luminance, ROM word alongside
   logic [15:0] rom_q_ff;
   logic [32:0] gain_prod_ff;  // stage 4
   logic [16:0] v_ff;          // stage 5: clamped level
   logic [32:0] sq_ff;         // stage 6
   logic [17:0] tail_ff;
   logic [50:0] cube_ff;       // stage 7
   logic [6:0]  glyph_ff;      // stage 8

   // the whole pipe moves unless its last item cannot enter the queue
   assign advance  = !(valid_ff[7] && queue_full);
   assign in_ready = advance;
   assign push     = valid_ff[7] && !queue_full;
   assign push_item.glyph   = glyph_ff;
   assign push_item.color   = color_ff[7];
   assign push_item.row_end = row_end_ff[7];

   // stage 1 combinational: color pick and weighted sum
   logic [23:0] s1_color;
   logic [24:0] s1_sum;
   always_comb begin
      if (cfg.single_channel) begin
         s1_color = {in_red, in_red, in_red};
         s1_sum   = {1'b0, in_red, 16'd0} + 25'(ROUND_255);
      end else begin
         s1_color = {in_red, in_green, in_blue};
         s1_sum   = 25'(in_red * WEIGHT_RED) + 25'(in_green * WEIGHT_GREEN)
                  + 25'(in_blue * WEIGHT_BLUE) + 25'(ROUND_255);
      end
   end

   // stage 2 combinational: divide by 255 via reciprocal
   logic [48:0] s2_prod;
   assign s2_prod = num_ff * RECIP_255;

   // stage 3 combinational: ROM address
   logic [16:0]                 s3_shifted;
   logic [GAMMA_INDEX_BITS-1:0] s3_idx;
   assign s3_shifted = lum2_ff >> IDX_SHIFT;
   assign s3_idx     = s3_shifted[GAMMA_INDEX_BITS-1:0];

   // stage 4 combinational: gamma select then gain
   logic [16:0] s4_lum;
   always_comb begin
      if (cfg.gamma_enable && (lum3_ff != '0) && !lum3_ff[16]) s4_lum = {1'b0, rom_q_ff};
      else s4_lum = lum3_ff;
   end

   // stage 5 combinational: round, add brightness, clamp to 0..1
   logic [33:0]        s5_rounded;
   logic signed [23:0] s5_sum;
   logic [16:0]        s5_v;
   always_comb begin
      s5_rounded = {1'b0, gain_prod_ff} + 34'd2048;
      s5_sum     = signed'({2'b00, s5_rounded[33:12]}) + 24'(cfg.brightness_offset);
      if (s5_sum < 0) s5_v = '0;
      else if (s5_sum > signed'(24'(ONE_Q16))) s5_v = ONE_Q16;
      else s5_v = s5_sum[16:0];
   end

   // stage 6 combinational: square and 3 - 2v
   logic [33:0] s6_sq;
   assign s6_sq = v_ff * v_ff;

   // stage 8 combinational: round the cubic, scale to the set size, clamp
   logic [51:0] s8_round;
   logic [16:0] s8_s;
   logic [6:0]  s8_max;
   logic [23:0] s8_scaled;
   logic [7:0]  s8_idx;
   logic [6:0]  s8_glyph;
   always_comb begin
      s8_round = {1'b0, cube_ff} + 52'h0_0000_8000_0000;
      s8_s     = s8_round[48:32];
      case (cfg.glyph_set)
         GSET_FINE:  s8_max = GMAX_FINE;
         GSET_BLOCK: s8_max = GMAX_BLOCK;
         default:    s8_max = GMAX_CLEAN;
      endcase
      s8_scaled = s8_s * s8_max;
      s8_idx    = s8_scaled[23:16];
      if (s8_idx > {1'b0, s8_max}) s8_glyph = s8_max;
      else s8_glyph = s8_idx[6:0];
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[6:0], in_valid};
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         color_ff[0]   <= s1_color;
         row_end_ff[0] <= in_row_end;
         for (int k = 1; k < 8; k++) begin
            color_ff[k]   <= color_ff[k-1];
            row_end_ff[k] <= row_end_ff[k-1];
         end
         num_ff       <= s1_sum[23:0];
         lum2_ff      <= s2_prod[48:32];
         lum3_ff      <= lum2_ff;
         rom_q_ff     <= gamma_rom[s3_idx];
         gain_prod_ff <= s4_lum * cfg.contrast_gain;
         v_ff         <= s5_v;
         sq_ff        <= s6_sq[32:0];
         tail_ff      <= SMOOTH_THREE - {v_ff, 1'b0};
         cube_ff      <= sq_ff * tail_ff;
         glyph_ff     <= s8_glyph;
      end
   end

endmodule

`default_nettype wire

// File: rtl/p2g_back.sv
// Back end: merges equal glyphs into runs and drives the result register.
// Depends on p2g_pkg; drains p2g_queue.
`default_nettype none

module p2g_back
   import p2g_pkg::*;
#(
   parameter int MAX_ROW_PIXELS = 1024
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          color_enable,
   input  wire p2g_queue_out_type qout,
   output logic               pop,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [6:0]         out_glyph,
   output logic [23:0]        out_color,
   output logic [10:0]        out_length,
   output logic               out_last
);

   localparam logic [10:0] LEN_CAP = (MAX_ROW_PIXELS > 2047) ? 11'd2047 : 11'(MAX_ROW_PIXELS);

   // pending run
   logic        pend_valid_ff, pend_valid_in;
   logic [6:0]  pend_glyph_ff, pend_glyph_in;
   logic [23:0] pend_color_ff, pend_color_in;
   logic [10:0] pend_len_ff, pend_len_in;
   // head already merged, only its row close is left
   logic        split_ff, split_in;
   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  rsp_glyph_ff, rsp_glyph_in;
   logic [23:0] rsp_color_ff, rsp_color_in;
   logic [10:0] rsp_len_ff, rsp_len_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        out_free, match;
   logic [10:0] len_ext;

   assign out_valid  = rsp_valid_ff;
   assign out_glyph  = rsp_glyph_ff;
   assign out_color  = rsp_color_ff;
   assign out_length = rsp_len_ff;
   assign out_last   = rsp_last_ff;

   assign out_free = !rsp_valid_ff || out_ready;
   assign match    = pend_valid_ff && (qout.head.glyph == pend_glyph_ff)
                   && (!color_enable || (qout.head.color == pend_color_ff));
   assign len_ext  = (pend_len_ff < LEN_CAP) ? pend_len_ff + 11'd1 : pend_len_ff;

   // merge decision, one queue action per cycle
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_glyph_in = pend_glyph_ff;
      pend_color_in = pend_color_ff;
      pend_len_in   = pend_len_ff;
      split_in      = split_ff;
      rsp_valid_in  = rsp_valid_ff && !out_ready;
      rsp_glyph_in  = rsp_glyph_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      pop           = 1'b0;
      if (!qout.empty) begin
         if (split_ff) begin
            // close the row with the run this pixel opened
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_glyph_in  = pend_glyph_ff;
               rsp_color_in  = pend_color_ff;
               rsp_len_in    = pend_len_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               split_in      = 1'b0;
               pop           = 1'b1;
            end
         end else if (match) begin
            if (!qout.head.row_end) begin
               pend_len_in = len_ext;
               pop         = 1'b1;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_glyph_in  = pend_glyph_ff;
               rsp_color_in  = pend_color_ff;
               rsp_len_in    = len_ext;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               pop           = 1'b1;
            end
         end else if (pend_valid_ff) begin
            // run broken: emit it and open a new one
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_glyph_in  = pend_glyph_ff;
               rsp_color_in  = pend_color_ff;
               rsp_len_in    = pend_len_ff;
               rsp_last_in   = 1'b0;
               pend_glyph_in = qout.head.glyph;
               pend_color_in = qout.head.color;
               pend_len_in   = 11'd1;
               if (qout.head.row_end) split_in = 1'b1;
               else pop = 1'b1;
            end
         end else if (!qout.head.row_end) begin
            pend_valid_in = 1'b1;
            pend_glyph_in = qout.head.glyph;
            pend_color_in = qout.head.color;
            pend_len_in   = 11'd1;
            pop           = 1'b1;
         end else if (out_free) begin
            // single-pixel run that also closes the row
            rsp_valid_in = 1'b1;
            rsp_glyph_in = qout.head.glyph;
            rsp_color_in = qout.head.color;
            rsp_len_in   = 11'd1;
            rsp_last_in  = 1'b1;
            pop          = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         split_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         split_ff      <= split_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_glyph_ff <= pend_glyph_in;
      pend_color_ff <= pend_color_in;
      pend_len_ff   <= pend_len_in;
      rsp_glyph_ff  <= rsp_glyph_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

`default_nettype wire

// File: rtl/p2g_checker.sv
// Port-level checks for the pixel-to-glyph run encoder, bound to its top level.
// Depends only on the top level's port names.
`default_nettype none

module p2g_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // every run counts at least one pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[41:31] != 11'd0)
      else $error("empty run emitted");

   // glyph stays inside the largest set
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:0] <= 7'd67)
      else $error("glyph index out of range");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind pixel_to_glyph_run_encoder_core p2g_checker u_p2g_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for pixel_to_glyph_run_encoder_core: a directed table and
// random pixel streams, each run checked against a table entry or in-bench predictor.
// Depends on p2g_pkg and the encoder RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import p2g_pkg::*;

   localparam int ROW_LIMIT     = 1024;
   localparam int GAMMA_X100    = 220;
   localparam int GAMMA_BITS    = 10;
   localparam int GAMMA_SIZE    = 1 << GAMMA_BITS;
   localparam int LEN_CAP       = (ROW_LIMIT > 2047) ? 2047 : ROW_LIMIT;
   localparam int DRAIN_CYCLES  = 40;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PIXELS = 650;
   localparam int LONG_RUN      = 1030;

   // write to an index with no register behind it
   localparam logic [2:0] CSR_UNMAPPED = 3'd7;
   // unused glyph set code, decodes as the clean set
   localparam logic [1:0] GSET_ALIAS   = 2'd3;

   typedef struct packed {
      logic       row_end;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_t;

   typedef struct packed {
      logic [6:0]  glyph;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [10:0] length;
      logic        last;
   } run_t;

   // one line of the directed table: a pixel or a register write
   typedef struct {
      bit          is_csr;
      pixel_t      px;
      logic [2:0]  sel;
      logic [17:0] val;
      bit          typed;
      logic [6:0]  want_glyph;
   } row_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // red [7:0], green [15:8], blue [23:16]
   logic        req_tlast;   // row_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // glyph [6:0], run_red [14:7], run_green [22:15],
                             // run_blue [30:23], run_length [41:31], zero [47:42]
   logic        rsp_tlast;   // last_in_row
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [17:0] csr_wdata;

   // predictor copy of settings and pending run
   logic [15:0]        gamma_rom [GAMMA_SIZE];
   logic               cfg_color_en;
   logic [1:0]         cfg_glyph_set;
   logic               cfg_gamma_en;
   logic [15:0]        cfg_gain;
   logic signed [17:0] cfg_bright;
   logic               cfg_single;
   logic               run_open;
   logic [6:0]         run_glyph;
   logic [23:0]        run_color;
   logic [10:0]        run_len;

   run_t expected_runs [$];
   int   fail_count  = 0;
   int   shown       = 0;
   int   idle_cycles = 0;
   bit   calm        = 1'b0;

   pixel_to_glyph_run_encoder_core #(
      .MAX_ROW_PIXELS   (ROW_LIMIT),
      .GAMMA_TIMES_100  (GAMMA_X100),
      .GAMMA_INDEX_BITS (GAMMA_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // log2 in Q24, truncating repeated squaring
   function automatic longint log2_q24(input longint unsigned n);
      longint unsigned t;
      longint unsigned m;
      longint          r;
      int              k;
      if (n == 0) return 0;
      t = n;
      k = 0;
      while (t > 1) begin
         t = t >> 1;
         k++;
      end
      m = n << (30 - k);
      r = longint'(k) <<< 24;
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            r = r + (64'sd1 <<< i);
         end
      end
      return r;
   endfunction

   // gamma ROM contents: largest y whose scaled log does not exceed the index's log
   initial begin : gamma_rom_build
      longint target;
      longint lhs;
      longint lo;
      longint hi;
      longint mid;
      for (int i = 0; i < GAMMA_SIZE; i++) begin
         target = 100 * (log2_q24(2 * i + 1) - (longint'(GAMMA_BITS + 1) <<< 24));
         lo = 0;
         hi = 65535;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = GAMMA_X100 * (log2_q24(mid) - (64'sd16 <<< 24));
            if (lhs <= target) lo = mid;
            else hi = mid - 1;
         end
         gamma_rom[i] = lo[15:0];
      end
   end

   // luminance -> gamma -> contrast/brightness -> smoothstep -> glyph index
   function automatic logic [6:0] glyph_of_pixel(input logic [7:0] r, g, b);
      longint unsigned lum;
      longint unsigned sq;
      longint unsigned s;
      longint unsigned idx;
      longint unsigned top;
      longint          v;
      if (cfg_single) lum = (64'(r) * 65536 + 127) / 255;
      else lum = (64'(r) * 19595 + 64'(g) * 38470 + 64'(b) * 7471 + 127) / 255;
      if (cfg_gamma_en && lum > 0 && lum < 65536) lum = gamma_rom[lum >> (16 - GAMMA_BITS)];
      v = longint'((lum * cfg_gain + 2048) >> 12) + longint'(cfg_bright);
      if (v < 0) v = 0;
      if (v > 65536) v = 65536;
      sq = v * v;
      s = (sq * longint'(196608 - 2 * v) + 64'h8000_0000) >> 32;
      top = (cfg_glyph_set == GSET_FINE) ? 67 : (cfg_glyph_set == GSET_BLOCK) ? 4 : 9;
      idx = (s * top) >> 16;
      if (idx > top) idx = top;
      return idx[6:0];
   endfunction

   // run merge; queues the runs a pixel closes unless the caller supplies its own
   task automatic merge_pixel(input pixel_t px, input bit keep);
      logic [7:0]  g;
      logic [7:0]  b;
      logic [6:0]  glyph;
      logic [23:0] color;
      g = cfg_single ? px.red : px.green;
      b = cfg_single ? px.red : px.blue;
      glyph = glyph_of_pixel(px.red, g, b);
      color = {px.red, g, b};
      if (run_open && glyph == run_glyph && (!cfg_color_en || color == run_color)) begin
         if (run_len < LEN_CAP) run_len++;
      end else begin
         if (run_open && keep)
            expected_runs.push_back('{run_glyph, run_color[23:16], run_color[15:8],
                                      run_color[7:0], run_len, 1'b0});
         run_open  = 1'b1;
         run_glyph = glyph;
         run_color = color;
         run_len   = 11'd1;
      end
      if (px.row_end) begin
         if (keep)
            expected_runs.push_back('{run_glyph, run_color[23:16], run_color[15:8],
                                      run_color[7:0], run_len, 1'b1});
         run_open  = 1'b0;
         run_glyph = '0;
         run_color = '0;
         run_len   = '0;
      end
   endtask

   // one pixel transaction; called and returns at a falling edge
   task automatic send_pixel(input pixel_t px, input bit typed, input run_t typed_run);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {px.blue, px.green, px.red};
      req_tlast  = px.row_end;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      merge_pixel(px, !typed);
      if (typed) expected_runs.push_back(typed_run);
      @(negedge clock);
   endtask

   // register write once the pipeline has drained
   task automatic write_reg(input logic [2:0] sel, input logic [17:0] val);
      req_tvalid = 1'b0;
      while (expected_runs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_index = sel;
      csr_wdata = val;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we    = 1'b0;
      case (sel)
         CSR_COLOR_ENABLE:      cfg_color_en  = val[0];
         CSR_GLYPH_SET:         cfg_glyph_set = val[1:0];
         CSR_GAMMA_ENABLE:      cfg_gamma_en  = val[0];
         CSR_CONTRAST_GAIN:     cfg_gain      = val[15:0];
         CSR_BRIGHTNESS_OFFSET: cfg_bright    = val;
         CSR_SINGLE_CHANNEL:    cfg_single    = val[0];
         default: ;
      endcase
   endtask

   // register value with optional junk above its width
   function automatic logic [17:0] pad_noise(input bit dirty, input int width,
                                             input logic [17:0] value);
      logic [17:0] mask;
      mask = (18'h1 << width) - 18'h1;
      return dirty ? ((18'($urandom) & ~mask) | (value & mask)) : (value & mask);
   endfunction

   function automatic row_t pixel_row(input logic [7:0] r, g, b, input logic row_end);
      row_t row;
      row = '{default: '0};
      row.px = '{row_end, b, g, r};
      return row;
   endfunction

   // single-pixel row whose glyph is obvious
   function automatic row_t known_row(input logic [7:0] r, g, b, input logic [6:0] glyph);
      row_t row;
      row = pixel_row(r, g, b, 1'b1);
      row.typed = 1'b1;
      row.want_glyph = glyph;
      return row;
   endfunction

   function automatic row_t reg_row(input logic [2:0] sel, input logic [17:0] val);
      row_t row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.sel = sel;
      row.val = val;
      return row;
   endfunction

   function automatic string describe_run(input run_t run);
      return $sformatf("glyph=%0d rgb=%0d,%0d,%0d len=%0d last=%0d",
                       run.glyph, run.red, run.green, run.blue, run.length, run.last);
   endfunction

   // result side: random stall before each transaction
   initial begin : rsp_ready_drive
      int unsigned stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // compare each run against the oldest expectation
   always @(posedge clock) begin : run_check
      run_t got;
      run_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[6:0], rsp_tdata[14:7], rsp_tdata[22:15], rsp_tdata[30:23],
                 rsp_tdata[41:31], rsp_tlast};
         if (expected_runs.size() == 0) begin
            fail_count++;
            if (shown < 10) $display("unexpected run: %s", describe_run(got));
            shown++;
         end else begin
            want = expected_runs.pop_front();
            if (got !== want) begin
               fail_count++;
               if (shown < 10)
                  $display("run mismatch: expected %s, got %s",
                           describe_run(want), describe_run(got));
               shown++;
            end
         end
      end
   end

   // hang detection
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("[pixel_to_glyph_run_encoder_core] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      row_t        directed_rows [$];
      row_t        row;
      pixel_t      px;
      logic [23:0] palette [3];
      logic [17:0] bright;
      logic [15:0] gain;
      bit          dirty;
      bit          open_end;
      int          random_sent;
      int          rows;
      int          len;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      cfg_color_en  = 1'b0;
      cfg_glyph_set = GSET_CLEAN;
      cfg_gamma_en  = 1'b0;
      cfg_gain      = 16'd4096;
      cfg_bright    = '0;
      cfg_single    = 1'b0;
      run_open  = 1'b0;
      run_glyph = '0;
      run_color = '0;
      run_len   = '0;
      random_sent = 0;

      // directed table, reset settings first
      directed_rows.push_back(known_row(8'd0, 8'd0, 8'd0, 7'd0));
      directed_rows.push_back(known_row(8'd255, 8'd255, 8'd255, 7'd9));
      directed_rows.push_back(pixel_row(8'd255, 8'd0, 8'd0, 1'b0));
      directed_rows.push_back(pixel_row(8'd255, 8'd0, 8'd0, 1'b0));
      directed_rows.push_back(pixel_row(8'd0, 8'd255, 8'd0, 1'b0));
      directed_rows.push_back(pixel_row(8'd0, 8'd0, 8'd255, 1'b0));
      directed_rows.push_back(pixel_row(8'd128, 8'd128, 8'd128, 1'b1));
      directed_rows.push_back(reg_row(CSR_UNMAPPED, 18'h3FFFF));
      // glyph set extremes, including the unused code
      directed_rows.push_back(reg_row(CSR_GLYPH_SET, GSET_FINE));
      directed_rows.push_back(known_row(8'd255, 8'd255, 8'd255, 7'd67));
      directed_rows.push_back(known_row(8'd0, 8'd0, 8'd0, 7'd0));
      directed_rows.push_back(reg_row(CSR_GLYPH_SET, GSET_BLOCK));
      directed_rows.push_back(known_row(8'd255, 8'd255, 8'd255, 7'd4));
      directed_rows.push_back(reg_row(CSR_GLYPH_SET, GSET_ALIAS));
      directed_rows.push_back(known_row(8'd255, 8'd255, 8'd255, 7'd9));
      directed_rows.push_back(reg_row(CSR_GLYPH_SET, GSET_CLEAN));
      // colour breaks runs
      directed_rows.push_back(reg_row(CSR_COLOR_ENABLE, 18'd1));
      directed_rows.push_back(pixel_row(8'd10, 8'd20, 8'd30, 1'b0));
      directed_rows.push_back(pixel_row(8'd10, 8'd20, 8'd31, 1'b0));
      directed_rows.push_back(pixel_row(8'd10, 8'd20, 8'd31, 1'b1));
      // grey mode: run colour is red repeated
      directed_rows.push_back(reg_row(CSR_SINGLE_CHANNEL, 18'd1));
      directed_rows.push_back(pixel_row(8'd200, 8'd1, 8'd2, 1'b0));
      directed_rows.push_back(pixel_row(8'd200, 8'd99, 8'd7, 1'b1));
      directed_rows.push_back(reg_row(CSR_GAMMA_ENABLE, 18'd1));
      directed_rows.push_back(known_row(8'd0, 8'd0, 8'd0, 7'd0));
      directed_rows.push_back(known_row(8'd255, 8'd255, 8'd255, 7'd9));
      directed_rows.push_back(pixel_row(8'd100, 8'd0, 8'd0, 1'b1));
      directed_rows.push_back(reg_row(CSR_SINGLE_CHANNEL, 18'd0));
      // brightness beyond full scale, clamped either way
      directed_rows.push_back(reg_row(CSR_CONTRAST_GAIN, 18'd0));
      directed_rows.push_back(reg_row(CSR_BRIGHTNESS_OFFSET, 18'h1FFFF));
      directed_rows.push_back(known_row(8'd0, 8'd0, 8'd0, 7'd9));
      directed_rows.push_back(reg_row(CSR_CONTRAST_GAIN, 18'hFFFF));
      directed_rows.push_back(reg_row(CSR_BRIGHTNESS_OFFSET, 18'd0));
      directed_rows.push_back(known_row(8'd255, 8'd255, 8'd255, 7'd9));
      directed_rows.push_back(reg_row(CSR_CONTRAST_GAIN, 18'd4096));
      directed_rows.push_back(reg_row(CSR_BRIGHTNESS_OFFSET, 18'h20000));
      directed_rows.push_back(known_row(8'd255, 8'd255, 8'd255, 7'd0));
      // settings change while a run is still open, no row end
      directed_rows.push_back(pixel_row(8'd5, 8'd5, 8'd5, 1'b0));
      directed_rows.push_back(reg_row(CSR_BRIGHTNESS_OFFSET, 18'd0));
      directed_rows.push_back(pixel_row(8'd5, 8'd5, 8'd5, 1'b0));
      directed_rows.push_back(pixel_row(8'd250, 8'd250, 8'd250, 1'b1));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr)
            write_reg(row.sel, row.val);
         else
            send_pixel(row.px, row.typed, '{row.want_glyph, row.px.red, row.px.green,
                                            row.px.blue, 11'd1, 1'b1});
      end

      // random phases: fresh settings, then rows built from a small palette
      while (random_sent < RANDOM_PIXELS) begin
         dirty = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0: gain = 16'd0;
            1: gain = 16'hFFFF;
            2: gain = 16'd4096;
            default: gain = 16'($urandom_range(2048, 8192));
         endcase
         case ($urandom_range(0, 7))
            0: bright = -18'sd65536;
            1: bright = 18'sd65536;
            2: bright = '0;
            3: bright = 18'h20000;
            4: bright = 18'h1FFFF;
            7: bright = 18'($urandom);
            default: bright = 18'($urandom_range(0, 40000)) - 18'd20000;
         endcase
         write_reg(CSR_COLOR_ENABLE, pad_noise(dirty, 1, 18'($urandom_range(0, 1))));
         write_reg(CSR_GLYPH_SET, pad_noise(dirty, 2, 18'($urandom_range(0, 3))));
         write_reg(CSR_GAMMA_ENABLE, pad_noise(dirty, 1, 18'($urandom_range(0, 1))));
         write_reg(CSR_CONTRAST_GAIN, pad_noise(dirty, 16, {2'b00, gain}));
         write_reg(CSR_BRIGHTNESS_OFFSET, bright);
         write_reg(CSR_SINGLE_CHANNEL, pad_noise(dirty, 1, 18'($urandom_range(0, 1))));
         calm = ($urandom_range(0, 3) == 0);
         rows = $urandom_range(3, 8);
         for (int r = 0; r < rows; r++) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
            open_end = ($urandom_range(0, 7) == 0);
            foreach (palette[c]) begin
               palette[c] = 24'($urandom);
               if ($urandom_range(0, 3) == 0) palette[c] = {3{palette[c][7:0]}};
            end
            px = {1'b0, palette[0]};
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: ;
                  5, 6, 7: px[23:0] = palette[$urandom_range(0, 2)];
                  default: px[23:0] = 24'($urandom);
               endcase
               px.row_end = (k == len - 1) && !open_end;
               send_pixel(px, 1'b0, '0);
               random_sent++;
            end
         end
      end

      // overlong run: zero gain keeps every glyph at zero, so the length saturates
      calm = 1'b0;
      write_reg(CSR_COLOR_ENABLE, 18'd0);
      write_reg(CSR_CONTRAST_GAIN, 18'd0);
      write_reg(CSR_BRIGHTNESS_OFFSET, 18'd0);
      for (int k = 0; k < LONG_RUN; k++) begin
         px = {1'b0, 24'($urandom)};
         px.row_end = (k == LONG_RUN - 1);
         send_pixel(px, 1'b0, '0);
      end

      req_tvalid = 1'b0;
      while (expected_runs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("[pixel_to_glyph_run_encoder_core] OK");
      else
         $display("[pixel_to_glyph_run_encoder_core] ERROR");
      $finish;
   end

endmodule

// File: files.f
rtl/p2g_pkg.sv
rtl/p2g_queue.sv
rtl/p2g_front.sv
rtl/p2g_back.sv
rtl/pixel_to_glyph_run_encoder_core.sv
rtl/p2g_checker.sv
tb/tb.sv
